### hdl/contiguous_bitmap_allocator_core_macros.svh
// Assertion macros shared by the allocator's checker.
// Depends on nothing; included by the checker file.
`ifndef CONTIGUOUS_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define CONTIGUOUS_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBA_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cba_checker: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBA_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cba_checker: assertion failed");

`endif

### hdl/cba_pkg.sv
// Shared constants and codes for the contiguous bitmap allocator.
// Depends on nothing; used by the core and its checker.
package cba_pkg;

    localparam int NUM_UNITS = 64;
    localparam int AW        = $clog2(NUM_UNITS);
    localparam int CW        = $clog2(NUM_UNITS + 1);
    localparam int FREE_SAT  = 127;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_ZERO  = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

endpackage

### hdl/contiguous_bitmap_allocator_core.sv
// Contiguous bitmap allocator: one occupancy bit per unit in a synchronous memory.
// Depends on cba_pkg.
// Clear, unknown, zero-length and oversized items go straight to the result stage; a unit
// write reads its old bit and then writes it; an allocate scans the units in order (all of
// them for best and worst fit) and then marks one unit per cycle through the single write port.
// One item is in work at a time. Reset (synchronous, active low) frees every unit at once.
module contiguous_bitmap_allocator_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [1:0] s_policy,
    input  logic [6:0] s_request_len,
    input  logic [5:0] s_unit_index,
    input  logic       s_unit_used,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [5:0] m_start_unit,
    output logic [6:0] m_free_units
);

    localparam int N  = cba_pkg::NUM_UNITS;
    localparam int AW = cba_pkg::AW;
    localparam int CW = cba_pkg::CW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WWB  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SEND = 3'd3;
    localparam logic [2:0] S_MARK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic          map_mem [N];
    logic          rd_data_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;

    logic [N-1:0]  valid_reg, valid_next;
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] free_reg, free_next;
    logic [CW-1:0] len_reg, len_next;
    logic [1:0]    policy_reg, policy_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic          wused_reg, wused_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] start_reg, start_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          p_vld_reg, p_vld_next;
    logic [AW-1:0] p_idx_reg, p_idx_next;
    logic [CW-1:0] run_len_reg, run_len_next;
    logic [AW-1:0] run_start_reg, run_start_next;
    logic          found_reg, found_next;
    logic [CW-1:0] best_len_reg, best_len_next;
    logic [AW-1:0] best_start_reg, best_start_next;
    logic [AW-1:0] mark_ptr_reg, mark_ptr_next;
    logic [CW-1:0] mark_cnt_reg, mark_cnt_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [5:0]    m_start_reg, m_start_next;
    logic [6:0]    m_free_reg, m_free_next;

    logic          bit_used;
    logic          close_take;
    logic [AW-1:0] cur_start;
    logic [CW-1:0] run_inc;
    logic          first_fit;
    logic [CW-1:0] mark_cnt_inc;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_start_unit = m_start_reg;
    assign m_free_units = m_free_reg;

    assign bit_used     = rd_vld_reg & rd_data_reg;
    assign first_fit    = (policy_reg != cba_pkg::POL_BEST) && (policy_reg != cba_pkg::POL_WORST);
    assign cur_start    = (run_len_reg == '0) ? p_idx_reg : run_start_reg;
    assign run_inc      = run_len_reg + CW'(1);
    assign mark_cnt_inc = mark_cnt_reg + CW'(1);

    always_comb begin
        close_take = 1'b0;
        if ((run_len_reg >= len_reg) && (run_len_reg != '0)) begin
            close_take = !found_reg ||
                         ((policy_reg == cba_pkg::POL_BEST) && (run_len_reg < best_len_reg)) ||
                         ((policy_reg == cba_pkg::POL_WORST) && (run_len_reg > best_len_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        free_next       = free_reg;
        len_next        = len_reg;
        policy_next     = policy_reg;
        widx_next       = widx_reg;
        wused_next      = wused_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        rd_ptr_next     = rd_ptr_reg;
        p_vld_next      = 1'b0;
        p_idx_next      = p_idx_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        mark_ptr_next   = mark_ptr_reg;
        mark_cnt_next   = mark_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_start_next    = m_start_reg;
        m_free_next     = m_free_reg;
        rd_addr         = rd_ptr_reg[AW-1:0];
        mem_we          = 1'b0;
        mem_waddr       = mark_ptr_reg;
        mem_wdata       = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                rd_addr = AW'(s_unit_index);
                if (s_valid) begin
                    status_next = cba_pkg::STAT_OK;
                    start_next  = '0;
                    state_next  = S_DONE;
                    unique case (s_command)
                        cba_pkg::CMD_ALLOC: begin
                            if (s_request_len == 7'd0) begin
                                status_next = cba_pkg::STAT_ZERO;
                            end else if (32'(s_request_len) > N) begin
                                status_next = cba_pkg::STAT_NOFIT;
                            end else begin
                                len_next     = CW'(s_request_len);
                                policy_next  = s_policy;
                                rd_ptr_next  = '0;
                                run_len_next = '0;
                                found_next   = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        cba_pkg::CMD_WRITE: begin
                            if (32'(s_unit_index) < N) begin
                                widx_next  = AW'(s_unit_index);
                                wused_next = s_unit_used;
                                state_next = S_WWB;
                            end
                        end
                        cba_pkg::CMD_CLEAR: begin
                            valid_next = '0;
                            free_next  = CW'(N);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WWB: begin
                mem_we                = 1'b1;
                mem_waddr             = widx_reg;
                mem_wdata             = wused_reg;
                valid_next[widx_reg]  = 1'b1;
                if (!bit_used && wused_reg) begin
                    free_next = free_reg - CW'(1);
                end else if (bit_used && !wused_reg) begin
                    free_next = free_reg + CW'(1);
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (rd_ptr_reg < CW'(N)) begin
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_ptr_reg[AW-1:0];
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                if (p_vld_reg) begin
                    if (!bit_used) begin
                        run_start_next = cur_start;
                        run_len_next   = run_inc;
                    end else begin
                        if (close_take) begin
                            found_next      = 1'b1;
                            best_len_next   = run_len_reg;
                            best_start_next = run_start_reg;
                        end
                        run_len_next = '0;
                    end
                    if (!bit_used && first_fit && (run_inc >= len_reg)) begin
                        start_next    = cur_start;
                        mark_ptr_next = cur_start;
                        mark_cnt_next = '0;
                        state_next    = S_MARK;
                    end else if (p_idx_reg == AW'(N - 1)) begin
                        state_next = S_SEND;
                    end
                end
            end
            S_SEND: begin
                run_len_next = '0;
                if (found_reg || close_take) begin
                    start_next    = close_take ? run_start_reg : best_start_reg;
                    mark_ptr_next = close_take ? run_start_reg : best_start_reg;
                    mark_cnt_next = '0;
                    state_next    = S_MARK;
                end else begin
                    status_next = cba_pkg::STAT_NOFIT;
                    start_next  = '0;
                    state_next  = S_DONE;
                end
            end
            S_MARK: begin
                mem_we                    = 1'b1;
                valid_next[mark_ptr_reg]  = 1'b1;
                mark_ptr_next             = mark_ptr_reg + AW'(1);
                mark_cnt_next             = mark_cnt_inc;
                if (mark_cnt_inc == len_reg) begin
                    free_next  = free_reg - len_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_start_next  = 6'(start_reg);
                    m_free_next   = (32'(free_reg) > cba_pkg::FREE_SAT) ?
                                    7'(cba_pkg::FREE_SAT) : 7'(free_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            free_reg    <= CW'(N);
            p_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            free_reg    <= free_next;
            p_vld_reg   <= p_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg        <= len_next;
        policy_reg     <= policy_next;
        widx_reg       <= widx_next;
        wused_reg      <= wused_next;
        status_reg     <= status_next;
        start_reg      <= start_next;
        rd_ptr_reg     <= rd_ptr_next;
        p_idx_reg      <= p_idx_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        found_reg      <= found_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        mark_ptr_reg   <= mark_ptr_next;
        mark_cnt_reg   <= mark_cnt_next;
        m_status_reg   <= m_status_next;
        m_start_reg    <= m_start_next;
        m_free_reg     <= m_free_next;
    end

endmodule

### hdl/cba_checker.sv
// Port-level checker for the contiguous bitmap allocator, with its bind.
// Depends on cba_pkg and contiguous_bitmap_allocator_core_macros.svh.
`include "contiguous_bitmap_allocator_core_macros.svh"

module cba_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [5:0] m_start_unit,
    input logic [6:0] m_free_units
);

    // A stalled result transfer keeps its payload.
    `CBA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_start_unit) && $stable(m_free_units))

    `CBA_ASSERT_IMP(a_status_legal, aclk, aresetn, m_valid, m_status != cba_pkg::STAT_BAD)

    // Refused or ignored requests report no start unit.
    `CBA_ASSERT_IMP(a_start_zero, aclk, aresetn, m_valid && (m_status == cba_pkg::STAT_NOFIT || m_status == cba_pkg::STAT_ZERO), m_start_unit == 6'd0)

    `CBA_ASSERT_IMP(a_free_bound, aclk, aresetn, m_valid, 32'(m_free_units) <= cba_pkg::NUM_UNITS)

    // An accepted item makes the input side busy in the next cycle.
    `CBA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind contiguous_bitmap_allocator_core cba_checker u_cba_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_start_unit (m_start_unit),
    .m_free_units (m_free_units)
);

### tb/tb_contiguous_bitmap_allocator_core.sv
// Self-checking testbench for contiguous_bitmap_allocator_core.
// It depends on cba_pkg and the core, and predicts each reply from its own occupancy map.
`timescale 1ns / 1ps

module tb_contiguous_bitmap_allocator_core;

    localparam logic [1:0] CMD_NOP    = 2'd3;
    localparam logic [1:0] POL_FIRST  = 2'd0;
    localparam logic [1:0] POL_ODD    = 2'd3;
    localparam int         RAND_ITEMS = 1900;
    localparam int         LIMIT      = 1000000;
    localparam int         DRAIN      = 140;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] start_unit;
        logic [6:0] free_units;
    } alloc_reply_t;

    class alloc_scoreboard;
        logic [cba_pkg::NUM_UNITS-1:0] occupied;
        alloc_reply_t                  predicted_replies[$];
        int                            errors;
        int                            replies_seen;

        function new();
            occupied     = '0;
            errors       = 0;
            replies_seen = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function bit find_fit(int len, logic [1:0] pol, output int start);
            int run_start;
            int run_len;
            int best_len;
            bit found;
            bit scan_all;
            run_start = 0;
            run_len   = 0;
            best_len  = 0;
            found     = 1'b0;
            start     = 0;
            scan_all  = (pol == cba_pkg::POL_BEST) || (pol == cba_pkg::POL_WORST);
            for (int i = 0; i <= cba_pkg::NUM_UNITS; i++) begin
                if (i < cba_pkg::NUM_UNITS && !occupied[i]) begin
                    if (run_len == 0) run_start = i;
                    run_len++;
                    if (!scan_all && run_len >= len) begin
                        start = run_start;
                        return 1'b1;
                    end
                end else begin
                    if (run_len > 0 && run_len >= len &&
                        (!found || (pol == cba_pkg::POL_BEST && run_len < best_len) ||
                         (pol == cba_pkg::POL_WORST && run_len > best_len))) begin
                        found    = 1'b1;
                        best_len = run_len;
                        start    = run_start;
                    end
                    run_len = 0;
                end
            end
            return found;
        endfunction

        function void note_input(logic [1:0] cmd, logic [1:0] pol, logic [6:0] len,
                                 logic [5:0] idx, logic used);
            alloc_reply_t r;
            int           st;
            int           nfree;
            r.status     = cba_pkg::STAT_OK;
            r.start_unit = '0;
            case (cmd)
                cba_pkg::CMD_ALLOC: begin
                    if (len == 0) begin
                        r.status = cba_pkg::STAT_ZERO;
                    end else if (len > cba_pkg::NUM_UNITS || !find_fit(len, pol, st)) begin
                        r.status = cba_pkg::STAT_NOFIT;
                    end else begin
                        r.start_unit = st[5:0];
                        for (int k = 0; k < len && st + k < cba_pkg::NUM_UNITS; k++)
                            occupied[st + k] = 1'b1;
                    end
                end
                cba_pkg::CMD_WRITE: begin
                    if (idx < cba_pkg::NUM_UNITS) occupied[idx] = used;
                end
                cba_pkg::CMD_CLEAR: begin
                    occupied = '0;
                end
                default: ;
            endcase
            nfree = 0;
            for (int i = 0; i < cba_pkg::NUM_UNITS; i++)
                if (!occupied[i]) nfree++;
            if (nfree > cba_pkg::FREE_SAT) nfree = cba_pkg::FREE_SAT;
            r.free_units = nfree[6:0];
            predicted_replies.push_back(r);
        endfunction

        task check_result(logic [1:0] status, logic [5:0] start_unit, logic [6:0] free_units);
            alloc_reply_t e;
            replies_seen++;
            if (predicted_replies.size() == 0) begin
                report("reply transfer with no reply predicted");
                return;
            end
            e = predicted_replies.pop_front();
            if (status !== e.status)
                report($sformatf("status %0d, predicted %0d", status, e.status));
            if (start_unit !== e.start_unit)
                report($sformatf("start_unit %0d, predicted %0d", start_unit, e.start_unit));
            if (free_units !== e.free_units)
                report($sformatf("free_units %0d, predicted %0d", free_units, e.free_units));
        endtask

        function int pending();
            return predicted_replies.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_command;
    logic [1:0] s_policy;
    logic [6:0] s_request_len;
    logic [5:0] s_unit_index;
    logic       s_unit_used;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_status;
    logic [5:0] m_start_unit;
    logic [6:0] m_free_units;

    alloc_scoreboard sb;
    int              burst_left;
    int              cycle_count;

    contiguous_bitmap_allocator_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_policy      (s_policy),
        .s_request_len (s_request_len),
        .s_unit_index  (s_unit_index),
        .s_unit_used   (s_unit_used),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_start_unit  (m_start_unit),
        .m_free_units  (m_free_units)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= LIMIT) begin
                $display("contiguous_bitmap_allocator_core test failed");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_command, s_policy, s_request_len, s_unit_index, s_unit_used);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_start_unit, m_free_units);
    end

    // The receiver alternates between always-ready, light and heavy stall stretches,
    // and once holds off for a long time so that the core backs up into its input.
    initial begin
        int  mode;
        int  phase_left;
        int  hold_left;
        bit  held;
        m_ready    = 1'b0;
        mode       = 0;
        phase_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && sb.replies_seen >= 40) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [1:0] pol, logic [6:0] len,
                             logic [5:0] idx, logic used);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_command     <= cmd;
        s_policy      <= pol;
        s_request_len <= len;
        s_unit_index  <= idx;
        s_unit_used   <= used;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic send_alloc(logic [1:0] pol, logic [6:0] len);
        send_item(cba_pkg::CMD_ALLOC, pol, len, 6'($urandom), 1'($urandom));
    endtask

    task automatic send_write(logic [5:0] idx, logic used);
        send_item(cba_pkg::CMD_WRITE, 2'($urandom), 7'($urandom), idx, used);
    endtask

    task automatic send_clear();
        send_item(cba_pkg::CMD_CLEAR, 2'($urandom), 7'($urandom), 6'($urandom),
                  1'($urandom));
    endtask

    task automatic run_directed();
        send_alloc(POL_FIRST, 7'd0);
        send_alloc(cba_pkg::POL_BEST, 7'd127);
        send_alloc(cba_pkg::POL_WORST, 7'd65);
        send_alloc(POL_ODD, 7'd64);
        send_alloc(cba_pkg::POL_BEST, 7'd1);
        send_item(CMD_NOP, 2'($urandom), 7'($urandom), 6'($urandom), 1'($urandom));
        send_write(6'd63, 1'b0);
        send_write(6'd0, 1'b0);
        send_alloc(cba_pkg::POL_WORST, 7'd1);
        send_clear();
        send_write(6'd5, 1'b1);
        send_write(6'd8, 1'b1);
        send_write(6'd20, 1'b1);
        send_write(6'd42, 1'b1);
        send_alloc(POL_FIRST, 7'd2);
        send_alloc(cba_pkg::POL_BEST, 7'd2);
        send_alloc(cba_pkg::POL_WORST, 7'd3);
        send_alloc(cba_pkg::POL_BEST, 7'd3);
        send_alloc(cba_pkg::POL_BEST, 7'd12);
        send_alloc(cba_pkg::POL_WORST, 7'd64);
        send_write(6'd63, 1'b1);
        send_write(6'd42, 1'b0);
        send_write(6'd21, 1'b0);
        send_alloc(POL_ODD, 7'd32);
        send_clear();
    endtask

    task automatic run_random();
        int         counted;
        int         pick;
        int         lenpick;
        logic [1:0] pol;
        logic [6:0] len;
        counted = 0;
        while (counted < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                pol     = ($urandom_range(0, 19) == 0) ? POL_ODD : 2'($urandom_range(0, 2));
                lenpick = $urandom_range(0, 99);
                if (lenpick < 80)      len = 7'($urandom_range(1, 12));
                else if (lenpick < 92) len = 7'($urandom_range(13, 64));
                else if (lenpick < 96) len = 7'd0;
                else                   len = 7'($urandom_range(65, 127));
                send_alloc(pol, len);
                counted++;
            end else if (pick < 92) begin
                send_write(6'($urandom), ($urandom_range(0, 3) == 0));
                counted++;
            end else if (pick < 97) begin
                send_clear();
                counted++;
            end else begin
                send_item(CMD_NOP, 2'($urandom), 7'($urandom), 6'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        sb            = new();
        burst_left    = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = cba_pkg::CMD_ALLOC;
        s_policy      = POL_FIRST;
        s_request_len = '0;
        s_unit_index  = '0;
        s_unit_used   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_directed();
        run_random();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("contiguous_bitmap_allocator_core test passed");
        end else begin
            $display("contiguous_bitmap_allocator_core test failed");
        end
        $finish;
    end

endmodule
